// ----- hdl/go_back_n_receiver_crc32_defines.svh -----
// Assertion macros for the Go-Back-N receiver.
// Included by the top level; the SYNTH define removes the assertion bodies.
`ifndef GO_BACK_N_RECEIVER_CRC32_DEFINES_SVH
`define GO_BACK_N_RECEIVER_CRC32_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define GBNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbnr assertion failed");

// Next-cycle implication, checked out of reset
`define GBNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbnr assertion failed");

`else

`define GBNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GBNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/gbnr_pkg.sv -----
// Types, codes and the CRC-32 byte update for the Go-Back-N receiver.
// No dependencies; used by go_back_n_receiver_crc32.
package gbnr_pkg;

  // Sizes
  localparam logic [9:0]  PAYLOAD_CAPACITY = 10'd1014;
  localparam logic [9:0]  LIMIT_RESET      = 10'd1014;

  // CRC-32, reflected
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Item modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_EOP     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_IGNORED   = 3'd0;
  localparam logic [2:0] VERDICT_ACCEPTED  = 3'd1;
  localparam logic [2:0] VERDICT_DUPLICATE = 3'd2;
  localparam logic [2:0] VERDICT_OUT_ORDER = 3'd3;
  localparam logic [2:0] VERDICT_TIMEOUT   = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [31:0] seq_number;
    logic [31:0] packet_crc;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        ack_valid;
    logic [31:0] ack_number;
    logic        commit;
    logic        transfer_done;
    logic [9:0]  payload_count;
    logic [31:0] bytes_total;
  } out_item_t;

  // Fold one byte into the running CRC, eight bit steps unrolled
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
    end
    return v;
  endfunction

endpackage

// ----- hdl/go_back_n_receiver_crc32.sv -----
// Go-Back-N receiver: per-packet CRC-32 check, byte count and ack decision.
// One item per clock is accepted unless the input side stalls; the result of
// an end-of-packet or timeout item is formed in the input register, where the
// CRC byte update and the sequence compare run, and is then held in the
// result register. Payload-byte items give no result. The input side stalls
// only when the result register holds an untaken result and the item in the
// input register would produce another. Configuration writes are always taken.
// Depends on gbnr_pkg and go_back_n_receiver_crc32_defines.svh.
`include "go_back_n_receiver_crc32_defines.svh"

module go_back_n_receiver_crc32 (
  input  logic               clk,
  input  logic               rst_n,
  // Input items
  input  logic               in_valid,
  output logic               in_ready,
  input  gbnr_pkg::in_item_t  in_data,
  // Results
  output logic               out_valid,
  input  logic               out_ready,
  output gbnr_pkg::out_item_t out_data,
  // Payload limit register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);

  // Configuration and packet state
  logic [9:0]  payload_limit_r;
  logic [31:0] crc_r,       crc_nxt;
  logic [9:0]  byte_count_r, byte_count_nxt;
  logic        oversize_r,  oversize_nxt;
  logic [31:0] expected_r,  expected_nxt;
  logic [31:0] committed_r, committed_nxt;

  // Pipeline registers
  logic                s1_valid_r;
  gbnr_pkg::in_item_t  s1_r;
  logic                out_valid_r;
  gbnr_pkg::out_item_t out_r;

  logic                res_valid;
  gbnr_pkg::out_item_t res;
  logic                s1_adv;
  logic [9:0]          lim;
  logic [31:0]         commit_sum;

  assign cfg_ready = 1'b1;

  // Limit capped at the buffer capacity
  assign lim = (payload_limit_r > gbnr_pkg::PAYLOAD_CAPACITY) ?
               gbnr_pkg::PAYLOAD_CAPACITY : payload_limit_r;

  // Results only for end-of-packet and timeout
  assign res_valid = (s1_r.mode == gbnr_pkg::MODE_EOP) ||
                     (s1_r.mode == gbnr_pkg::MODE_TIMEOUT);
  assign s1_adv    = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;

  assign commit_sum = committed_r + {22'd0, byte_count_r};

  // Per-item decision
  always_comb begin
    crc_nxt        = crc_r;
    byte_count_nxt = byte_count_r;
    oversize_nxt   = oversize_r;
    expected_nxt   = expected_r;
    committed_nxt  = committed_r;
    res            = '0;
    case (s1_r.mode)
      gbnr_pkg::MODE_BYTE: begin
        crc_nxt = gbnr_pkg::crc_fold(crc_r, s1_r.data_byte);
        if (byte_count_r < lim) begin
          byte_count_nxt = byte_count_r + 10'd1;
        end else begin
          oversize_nxt = 1'b1;
        end
      end
      gbnr_pkg::MODE_EOP: begin
        res.payload_count = byte_count_r;
        if (oversize_r || (~crc_r != s1_r.packet_crc)) begin
          res.verdict = gbnr_pkg::VERDICT_IGNORED;
        end else if (s1_r.seq_number == expected_r) begin
          res.verdict       = gbnr_pkg::VERDICT_ACCEPTED;
          res.ack_valid     = 1'b1;
          res.ack_number    = s1_r.seq_number;
          res.commit        = 1'b1;
          res.transfer_done = (byte_count_r < lim);
          committed_nxt     = commit_sum;
          expected_nxt      = expected_r + 32'd1;
        end else if (s1_r.seq_number < expected_r) begin
          res.verdict    = gbnr_pkg::VERDICT_DUPLICATE;
          res.ack_valid  = 1'b1;
          res.ack_number = s1_r.seq_number;
        end else begin
          res.verdict    = gbnr_pkg::VERDICT_OUT_ORDER;
          res.ack_valid  = 1'b1;
          res.ack_number = (expected_r != 32'd0) ? expected_r - 32'd1 : 32'd0;
        end
        res.bytes_total = committed_nxt;
        crc_nxt         = gbnr_pkg::CRC_INIT;
        byte_count_nxt  = 10'd0;
        oversize_nxt    = 1'b0;
        if (res.transfer_done) begin
          expected_nxt  = 32'd0;
          committed_nxt = 32'd0;
        end
      end
      gbnr_pkg::MODE_TIMEOUT: begin
        res.verdict       = gbnr_pkg::VERDICT_TIMEOUT;
        res.transfer_done = 1'b1;
        if (expected_r != 32'd0) begin
          res.ack_valid  = 1'b1;
          res.ack_number = expected_r - 32'd1;
        end
        res.bytes_total = committed_r;
        crc_nxt         = gbnr_pkg::CRC_INIT;
        byte_count_nxt  = 10'd0;
        oversize_nxt    = 1'b0;
        expected_nxt    = 32'd0;
        committed_nxt   = 32'd0;
      end
      default: begin
        // unused mode: no result, no state change
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_limit_r <= gbnr_pkg::LIMIT_RESET;
      crc_r           <= gbnr_pkg::CRC_INIT;
      byte_count_r    <= 10'd0;
      oversize_r      <= 1'b0;
      expected_r      <= 32'd0;
      committed_r     <= 32'd0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        payload_limit_r <= cfg_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        crc_r        <= crc_nxt;
        byte_count_r <= byte_count_nxt;
        oversize_r   <= oversize_nxt;
        expected_r   <= expected_nxt;
        committed_r  <= committed_nxt;
      end
      if (s1_adv && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `GBNR_ASSERT_IMP(a_commit_is_accept, clk, rst_n, out_valid_r && out_r.commit, out_r.ack_valid && (out_r.verdict == gbnr_pkg::VERDICT_ACCEPTED))
  `GBNR_ASSERT_IMP(a_ack_zero_when_none, clk, rst_n, out_valid_r && !out_r.ack_valid, out_r.ack_number == 32'd0)
  `GBNR_ASSERT_NXT(a_timeout_clears, clk, rst_n, s1_adv && (s1_r.mode == gbnr_pkg::MODE_TIMEOUT), (expected_r == 32'd0) && (byte_count_r == 10'd0) && !oversize_r)
  `GBNR_ASSERT_IMP(a_count_capped, clk, rst_n, 1'b1, byte_count_r <= gbnr_pkg::PAYLOAD_CAPACITY)
  `GBNR_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !s1_valid_r, in_ready)

endmodule
